// ===== hw/rtl/kinematic_bicycle_step_defines.svh =====
// assertion macros for the kinematic bicycle step block
// used by the port checker; expects clk_i and rst_ni in scope
`ifndef KINEMATIC_BICYCLE_STEP_DEFINES_SVH
`define KINEMATIC_BICYCLE_STEP_DEFINES_SVH

// checked outside reset only
`define KBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define KBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/kbs_pkg.sv =====
// shared types, constants and the cordic arctangent table
// for the kinematic bicycle step block; no dependencies
package kbs_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int CORDIC_ITERS_DEF = 18;
  localparam int TQ               = 30;
  localparam int RND_ANG          = TQ - FRAC_BITS;
  localparam int DIV_SH           = 14;
  localparam int DIV_BITS         = 18;
  localparam int IDXW             = 5;
  localparam int XW               = 48;
  localparam int ZW               = 36;
  localparam int PW               = 58;

  localparam logic signed [19:0] PI_F     = 20'sd205887;
  localparam logic signed [19:0] TWO_PI_F = 20'sd411775;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] GAIN_Q30    = 36'sd652032874;

  typedef enum logic [2:0] {
    CFG_MAX_ACCEL     = 3'd0,
    CFG_MAX_DECEL     = 3'd1,
    CFG_STEER_LIMIT   = 3'd2,
    CFG_AXLE_DIST     = 3'd3,
    CFG_START_X       = 3'd4,
    CFG_START_Y       = 3'd5,
    CFG_START_HEADING = 3'd6,
    CFG_START_SPEED   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_KW  = 3'd0,
    MUL_ADT = 3'd1,
    MUL_VC  = 3'd2,
    MUL_VS  = 3'd3,
    MUL_VN  = 3'd4,
    MUL_TDT = 3'd5,
    MUL_CW  = 3'd6
  } mul_op_e;

  typedef struct packed {
    logic signed [23:0] max_accel;
    logic signed [23:0] max_decel;
    logic [16:0]        steer_limit;
    logic [23:0]        axle_dist;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [18:0] start_heading;
    logic [23:0]        start_speed;
  } cfg_t;

  typedef struct packed {
    logic            capture;
    logic            load_start;
    logic            mul_en;
    mul_op_e         mul_op;
    logic            a_en;
    logic            st_en;
    logic            vn_en;
    logic            cor_init;
    logic            cor_vec;
    logic            cor_ang_st;
    logic            cor_step;
    logic [IDXW-1:0] cor_idx;
    logic            trig1_en;
    logic            trig2_en;
    logic            t_en;
    logic            dx_en;
    logic            dy_en;
    logic            num_en;
    logic            den_en;
    logic            div_init;
    logic            div_step;
    logic            fin_en;
    logic            pub_en;
  } cmd_t;

  // atan(2^-i) in Q0.30
  function automatic logic [29:0] atan_q30(input logic [IDXW-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/kinematic_bicycle_step.sv =====
// Kinematic bicycle step: each step request advances x, y, heading and speed
// by one forward Euler step; a restart request reloads the start registers.
// The block works on one request at a time and takes the next only once the
// result of the last is in the output register: one shared iterative CORDIC
// makes three passes (steering arctangent, sin/cos of heading, sin/cos of
// steering), a single shared multiplier runs nine products one after
// another, and the heading rate comes out of an 18-step restoring divider.
// The result sits in an output register, so the next request is accepted
// while it waits. Configuration is held in registers written through
// cfg_we_i. Depends on kbs_pkg, kbs_ctrl, kbs_datapath.
module kinematic_bicycle_step #(
  parameter int CORDIC_ITERS = kbs_pkg::CORDIC_ITERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [23:0] target_accel_i,
  input  logic signed [20:0] target_curvature_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [18:0] heading_o,
  output logic [23:0]        speed_o,
  output logic signed [23:0] applied_accel_o,
  output logic signed [17:0] steer_angle_o
);
  import kbs_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_accel     <= 24'sd131072;
      cfg_q.max_decel     <= -24'sd262144;
      cfg_q.steer_limit   <= 17'd32768;
      cfg_q.axle_dist     <= 24'd183501;
      cfg_q.start_x       <= '0;
      cfg_q.start_y       <= '0;
      cfg_q.start_heading <= '0;
      cfg_q.start_speed   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_ACCEL:     cfg_q.max_accel     <= cfg_wdata_i[23:0];
        CFG_MAX_DECEL:     cfg_q.max_decel     <= cfg_wdata_i[23:0];
        CFG_STEER_LIMIT:   cfg_q.steer_limit   <= cfg_wdata_i[16:0];
        CFG_AXLE_DIST:     cfg_q.axle_dist     <= cfg_wdata_i[23:0];
        CFG_START_X:       cfg_q.start_x       <= cfg_wdata_i;
        CFG_START_Y:       cfg_q.start_y       <= cfg_wdata_i;
        CFG_START_HEADING: cfg_q.start_heading <= cfg_wdata_i[18:0];
        CFG_START_SPEED:   cfg_q.start_speed   <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  kbs_ctrl #(
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  kbs_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg_q),
    .target_accel_i     (target_accel_i),
    .target_curvature_i (target_curvature_i),
    .time_step_i        (time_step_i),
    .pos_x_o            (pos_x_o),
    .pos_y_o            (pos_y_o),
    .heading_o          (heading_o),
    .speed_o            (speed_o),
    .applied_accel_o    (applied_accel_o),
    .steer_angle_o      (steer_angle_o)
  );

endmodule

// ===== hw/rtl/kbs_cordic.sv =====
// iterative cordic, one micro-rotation per step, vectoring or rotation mode
// depends on kbs_pkg
module kbs_cordic (
  input  logic                        clk_i,
  input  logic                        init_i,
  input  logic                        vec_i,
  input  logic signed [18:0]          ang_i,
  input  logic signed [45:0]          vy_i,
  input  logic                        step_i,
  input  logic [kbs_pkg::IDXW-1:0]    idx_i,
  output logic signed [31:0]          cos_o,
  output logic signed [31:0]          sin_o,
  output logic signed [kbs_pkg::ZW-1:0] z_o
);
  import kbs_pkg::*;

  logic signed [XW-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [ZW-1:0] z_q, z_d, zang, at;
  logic                 vec_q, vec_d, neg_q, neg_d, up;

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    vec_d = vec_q;
    neg_d = neg_q;
    zang  = ZW'(ang_i) <<< RND_ANG;
    dx    = y_q >>> idx_i;
    dy    = x_q >>> idx_i;
    at    = $signed({{(ZW-30){1'b0}}, atan_q30(idx_i)});
    up    = vec_q ? (y_q > 0) : z_q[ZW-1];
    if (init_i) begin
      neg_d = 1'b0;
      vec_d = vec_i;
      if (vec_i) begin
        x_d = {{(XW-2*FRAC_BITS-1){1'b0}}, 1'b1, {(2*FRAC_BITS){1'b0}}};
        y_d = XW'(vy_i);
        z_d = '0;
      end else begin
        x_d = XW'(GAIN_Q30);
        y_d = '0;
        // fold into the right half plane, negate the results later
        if (zang > HALF_PI_Q30) begin
          z_d   = zang - PI_Q30;
          neg_d = 1'b1;
        end else if (zang < -HALF_PI_Q30) begin
          z_d   = zang + PI_Q30;
          neg_d = 1'b1;
        end else begin
          z_d = zang;
        end
      end
    end else if (step_i) begin
      if (up) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    vec_q <= vec_d;
    neg_q <= neg_d;
  end

  assign cos_o = neg_q ? 32'(-x_q) : 32'(x_q);
  assign sin_o = neg_q ? 32'(-y_q) : 32'(y_q);
  assign z_o   = z_q;

endmodule

// ===== hw/rtl/kbs_datapath.sv =====
// datapath: input latch, shared multiplier, cordic, restoring divider,
// vehicle state and output registers; depends on kbs_pkg and kbs_cordic
module kbs_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kbs_pkg::cmd_t         cmd_i,
  input  kbs_pkg::cfg_t         cfg_i,
  input  logic signed [23:0]    target_accel_i,
  input  logic signed [20:0]    target_curvature_i,
  input  logic [15:0]           time_step_i,
  output logic signed [31:0]    pos_x_o,
  output logic signed [31:0]    pos_y_o,
  output logic signed [18:0]    heading_o,
  output logic [23:0]           speed_o,
  output logic signed [23:0]    applied_accel_o,
  output logic signed [17:0]    steer_angle_o
);
  import kbs_pkg::*;

  localparam int NUMW  = 57;
  localparam int DENW  = 42;
  localparam int RW    = 60;
  localparam int DEN_R = TQ - DIV_SH;

  // request latch
  logic signed [23:0] ta_q;
  logic signed [20:0] tk_q;
  logic [15:0]        dt_q;

  // step intermediates
  logic signed [PW-1:0]   p_q;
  logic signed [23:0]     a_q;
  logic signed [17:0]     st_q;
  logic [23:0]            vn_q;
  logic signed [31:0]     ch_q, sh_q, cs_q, sn_q;
  logic signed [25:0]     t_q;
  logic signed [27:0]     dx_q, dy_q;
  logic signed [NUMW-1:0] num_q;
  logic signed [DENW-1:0] den_q;

  // divider
  logic [RW-1:0]       r_q, d_q;
  logic [DIV_BITS-1:0] q_q;
  logic                zero_q, sat_q, qneg_q;

  // vehicle state
  logic signed [31:0] x_q, y_q;
  logic signed [18:0] h_q;
  logic [23:0]        v_q;
  logic signed [23:0] acc_q;
  logic signed [17:0] steer_q;

  logic signed [31:0] ma;
  logic signed [25:0] mb, mb_v, mb_wb, mb_dt;
  logic signed [PW-1:0] p_r30, p_r16, p_rden;
  logic signed [23:0] a_c;
  logic signed [17:0] lim, st_c;
  logic signed [ZW-1:0] z_w, st_r;
  logic signed [26:0] vsum;
  logic [23:0] vn_c;
  logic signed [31:0] cor_cos, cor_sin;
  logic signed [18:0] cor_ang;
  logic [RW-1:0] nabs, dabs;
  logic div_ge;
  logic [DIV_BITS-1:0] qmag;
  logic signed [19:0] mag, dth, hsum, hw, hstart;
  logic signed [32:0] xs, ys;
  logic signed [31:0] x_c, y_c;

  assign mb_v  = $signed({2'b0, v_q});
  assign mb_wb = $signed({2'b0, cfg_i.axle_dist});
  assign mb_dt = $signed({10'b0, dt_q});

  always_comb begin
    case (cmd_i.mul_op)
      MUL_KW:  begin ma = 32'(tk_q); mb = mb_wb; end
      MUL_ADT: begin ma = 32'(a_q);  mb = mb_dt; end
      MUL_VC:  begin ma = ch_q;      mb = mb_v;  end
      MUL_VS:  begin ma = sh_q;      mb = mb_v;  end
      MUL_VN:  begin ma = sn_q;      mb = mb_v;  end
      MUL_TDT: begin ma = 32'(t_q);  mb = mb_dt; end
      MUL_CW:  begin ma = cs_q;      mb = mb_wb; end
      default: begin ma = '0;        mb = '0;    end
    endcase
  end

  // round half up on the right shifts of the product
  assign p_r30  = (p_q + PW'(64'sd1 <<< (TQ - 1))) >>> TQ;
  assign p_r16  = (p_q + PW'(64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign p_rden = (p_q + PW'(64'sd1 <<< (DEN_R - 1))) >>> DEN_R;

  assign cor_ang = cmd_i.cor_ang_st ? 19'(st_q) : h_q;

  kbs_cordic u_cordic (
    .clk_i  (clk_i),
    .init_i (cmd_i.cor_init),
    .vec_i  (cmd_i.cor_vec),
    .ang_i  (cor_ang),
    .vy_i   (46'(p_q)),
    .step_i (cmd_i.cor_step),
    .idx_i  (cmd_i.cor_idx),
    .cos_o  (cor_cos),
    .sin_o  (cor_sin),
    .z_o    (z_w)
  );

  always_comb begin
    // max_decel wins when the limits cross
    a_c = (ta_q < cfg_i.max_accel) ? ta_q : cfg_i.max_accel;
    if (a_c < cfg_i.max_decel) begin
      a_c = cfg_i.max_decel;
    end
    lim  = $signed({1'b0, cfg_i.steer_limit});
    st_r = (z_w + ZW'(64'sd1 <<< (RND_ANG - 1))) >>> RND_ANG;
    if (st_r > ZW'(lim)) begin
      st_c = lim;
    end else if (st_r < -ZW'(lim)) begin
      st_c = -lim;
    end else begin
      st_c = 18'(st_r);
    end
    vsum = $signed({3'b0, v_q}) + 27'(p_r16);
    if (vsum < 0) begin
      vn_c = '0;
    end else if (vsum > 27'sd16777215) begin
      vn_c = 24'hFFFFFF;
    end else begin
      vn_c = 24'(vsum);
    end
    nabs   = RW'(num_q[NUMW-1] ? -num_q : num_q);
    dabs   = RW'(den_q[DENW-1] ? -den_q : den_q);
    div_ge = r_q >= d_q;
    if (zero_q) begin
      qmag = '0;
    end else if (sat_q || ({2'b0, q_q} > PI_F)) begin
      qmag = DIV_BITS'(PI_F);
    end else begin
      qmag = q_q;
    end
    mag  = $signed({2'b0, qmag});
    dth  = qneg_q ? -mag : mag;
    hsum = 20'(h_q) + dth;
    if (hsum > PI_F) begin
      hw = hsum - TWO_PI_F;
    end else if (hsum < -PI_F) begin
      hw = hsum + TWO_PI_F;
    end else begin
      hw = hsum;
    end
    xs = 33'(x_q) + 33'(dx_q);
    ys = 33'(y_q) + 33'(dy_q);
    if (xs > 33'sd2147483647) begin
      x_c = 32'sh7FFFFFFF;
    end else if (xs < -33'sd2147483648) begin
      x_c = 32'sh80000000;
    end else begin
      x_c = 32'(xs);
    end
    if (ys > 33'sd2147483647) begin
      y_c = 32'sh7FFFFFFF;
    end else if (ys < -33'sd2147483648) begin
      y_c = 32'sh80000000;
    end else begin
      y_c = 32'(ys);
    end
    if (20'(cfg_i.start_heading) > PI_F) begin
      hstart = PI_F;
    end else if (20'(cfg_i.start_heading) < -PI_F) begin
      hstart = -PI_F;
    end else begin
      hstart = 20'(cfg_i.start_heading);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ta_q <= target_accel_i;
      tk_q <= target_curvature_i;
      dt_q <= time_step_i;
    end
    if (cmd_i.mul_en) p_q <= ma * mb;
    if (cmd_i.a_en) a_q <= a_c;
    if (cmd_i.st_en) st_q <= st_c;
    if (cmd_i.vn_en) vn_q <= vn_c;
    if (cmd_i.trig1_en) begin
      ch_q <= cor_cos;
      sh_q <= cor_sin;
    end
    if (cmd_i.trig2_en) begin
      cs_q <= cor_cos;
      sn_q <= cor_sin;
    end
    if (cmd_i.t_en) t_q <= 26'(p_r30);
    if (cmd_i.dx_en) dx_q <= 28'(p_r16);
    if (cmd_i.dy_en) dy_q <= 28'(p_r16);
    if (cmd_i.num_en) num_q <= NUMW'(p_q) <<< DIV_SH;
    if (cmd_i.den_en) den_q <= DENW'(p_rden);
    if (cmd_i.div_init) begin
      zero_q <= (num_q == 0);
      sat_q  <= {1'b0, nabs} >= ({1'b0, dabs} << DIV_BITS);
      qneg_q <= num_q[NUMW-1] ^ den_q[DENW-1];
      r_q    <= nabs;
      d_q    <= dabs << (DIV_BITS - 1);
      q_q    <= '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) r_q <= r_q - d_q;
      q_q <= {q_q[DIV_BITS-2:0], div_ge};
      d_q <= d_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= '0;
      y_q     <= '0;
      h_q     <= '0;
      v_q     <= '0;
      acc_q   <= '0;
      steer_q <= '0;
    end else if (cmd_i.load_start) begin
      x_q     <= cfg_i.start_x;
      y_q     <= cfg_i.start_y;
      h_q     <= 19'(hstart);
      v_q     <= cfg_i.start_speed;
      acc_q   <= '0;
      steer_q <= '0;
    end else if (cmd_i.fin_en) begin
      x_q     <= x_c;
      y_q     <= y_c;
      h_q     <= 19'(hw);
      v_q     <= vn_q;
      acc_q   <= a_q;
      steer_q <= st_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pub_en) begin
      pos_x_o         <= x_q;
      pos_y_o         <= y_q;
      heading_o       <= h_q;
      speed_o         <= v_q;
      applied_accel_o <= acc_q;
      steer_angle_o   <= steer_q;
    end
  end

endmodule

// ===== hw/rtl/kbs_ctrl.sv =====
// sequencer for one step or restart request: multiplier ops, three cordic passes,
// divider and result hand-off; depends on kbs_pkg
module kbs_ctrl #(
  parameter int CORDIC_ITERS = kbs_pkg::CORDIC_ITERS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          kind_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output kbs_pkg::cmd_t cmd_o
);
  import kbs_pkg::*;

  typedef enum logic [25:0] {
    ST_IDLE  = 26'd1 << 0,
    ST_LOAD  = 26'd1 << 1,
    ST_MKW   = 26'd1 << 2,
    ST_VINIT = 26'd1 << 3,
    ST_VITER = 26'd1 << 4,
    ST_STEER = 26'd1 << 5,
    ST_SPD   = 26'd1 << 6,
    ST_R1    = 26'd1 << 7,
    ST_TRIG1 = 26'd1 << 8,
    ST_R2    = 26'd1 << 9,
    ST_TRIG2 = 26'd1 << 10,
    ST_MVC   = 26'd1 << 11,
    ST_RX    = 26'd1 << 12,
    ST_MX    = 26'd1 << 13,
    ST_LX    = 26'd1 << 14,
    ST_RY    = 26'd1 << 15,
    ST_MY    = 26'd1 << 16,
    ST_LY    = 26'd1 << 17,
    ST_RN    = 26'd1 << 18,
    ST_MN    = 26'd1 << 19,
    ST_LN    = 26'd1 << 20,
    ST_LD    = 26'd1 << 21,
    ST_DCHK  = 26'd1 << 22,
    ST_DITER = 26'd1 << 23,
    ST_FIN   = 26'd1 << 24,
    ST_PUB   = 26'd1 << 25
  } state_e;

  state_e state_q, state_d;
  logic [IDXW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic last_cor, last_div, slot_free;

  assign last_cor  = cnt_q == IDXW'(CORDIC_ITERS - 1);
  assign last_div  = cnt_q == IDXW'(DIV_BITS - 1);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.mul_op = MUL_KW;
    cmd_o.cor_idx = cnt_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = kind_i ? ST_LOAD : ST_MKW;
      end
      ST_LOAD: begin
        cmd_o.load_start = 1'b1;
        state_d = ST_PUB;
      end
      ST_MKW: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_KW;
        state_d = ST_VINIT;
      end
      ST_VINIT: begin
        cmd_o.cor_init = 1'b1;
        cmd_o.cor_vec  = 1'b1;
        cnt_d   = '0;
        state_d = ST_VITER;
      end
      ST_VITER: begin
        cmd_o.cor_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (last_cor) state_d = ST_STEER;
      end
      ST_STEER: begin
        cmd_o.st_en = 1'b1;
        cmd_o.a_en  = 1'b1;
        state_d = ST_SPD;
      end
      ST_SPD: begin
        // speed product and heading rotation start together
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_op   = MUL_ADT;
        cmd_o.cor_init = 1'b1;
        cnt_d   = '0;
        state_d = ST_R1;
      end
      ST_R1: begin
        cmd_o.cor_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (last_cor) state_d = ST_TRIG1;
      end
      ST_TRIG1: begin
        cmd_o.trig1_en   = 1'b1;
        cmd_o.vn_en      = 1'b1;
        cmd_o.cor_init   = 1'b1;
        cmd_o.cor_ang_st = 1'b1;
        cnt_d   = '0;
        state_d = ST_R2;
      end
      ST_R2: begin
        cmd_o.cor_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (last_cor) state_d = ST_TRIG2;
      end
      ST_TRIG2: begin
        cmd_o.trig2_en = 1'b1;
        state_d = ST_MVC;
      end
      ST_MVC: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_VC;
        state_d = ST_RX;
      end
      ST_RX: begin
        cmd_o.t_en = 1'b1;
        state_d = ST_MX;
      end
      ST_MX: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_TDT;
        state_d = ST_LX;
      end
      ST_LX: begin
        cmd_o.dx_en  = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_VS;
        state_d = ST_RY;
      end
      ST_RY: begin
        cmd_o.t_en = 1'b1;
        state_d = ST_MY;
      end
      ST_MY: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_TDT;
        state_d = ST_LY;
      end
      ST_LY: begin
        cmd_o.dy_en  = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_VN;
        state_d = ST_RN;
      end
      ST_RN: begin
        cmd_o.t_en = 1'b1;
        state_d = ST_MN;
      end
      ST_MN: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_TDT;
        state_d = ST_LN;
      end
      ST_LN: begin
        cmd_o.num_en = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_CW;
        state_d = ST_LD;
      end
      ST_LD: begin
        cmd_o.den_en = 1'b1;
        state_d = ST_DCHK;
      end
      ST_DCHK: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = ST_DITER;
      end
      ST_DITER: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (last_div) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin_en = 1'b1;
        state_d = ST_PUB;
      end
      ST_PUB: begin
        // wait for the output register to free up
        if (slot_free) begin
          cmd_o.pub_en = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/kbs_checker.sv =====
// port-level checker for the kinematic bicycle step block, bound to the top
// depends on kbs_pkg and kinematic_bicycle_step_defines.svh
`include "kinematic_bicycle_step_defines.svh"

module kbs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [18:0] heading_o
);
  import kbs_pkg::*;

  // one request in flight at a time
  `KBS_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accept")

  // a result is only published from a busy sequencer
  `KBS_ASSERT(a_result_from_work, $rose(out_valid_o) |-> $past(!in_ready_o), "result from idle")

  `KBS_ASSERT(a_result_held, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // heading wrapped into [-pi, pi] whenever a result is valid
  `KBS_ASSERT_ALWAYS(a_heading_range, out_valid_o |-> heading_o <= PI_F && heading_o >= -PI_F, "heading out of range")

endmodule

bind kinematic_bicycle_step kbs_checker u_kbs_checker (.*);
